// ===== sv/hsl2rgb_pkg.sv =====
// ============================================================================
// hsl2rgb_pkg
// Shared constants and types for the HSL to RGB conversion pipeline.
// ============================================================================
package hsl2rgb_pkg;

    // Default number of fraction bits for internal fixed-point values.
    localparam int FRAC_BITS_DEF = 16;

    // Register stages from input to output, output register included.
    localparam int PIPE_STAGES = 7;

    // Input ranges.
    localparam logic [8:0] HUE_RANGE = 9'd360;
    localparam logic [6:0] PCT_MAX   = 7'd100;

    // Reciprocals for the small remainder divides: ceil(2^K / d).
    // Exact over the remainder range that reaches them (below 360*360 and 100*100).
    localparam logic [17:0] HUE_RECIP       = 18'd186414;
    localparam int          HUE_RECIP_SHIFT = 26;
    localparam logic [13:0] PCT_RECIP       = 14'd10486;
    localparam int          PCT_RECIP_SHIFT = 20;

    // Load enables of the stages that the per-channel ramp units own.
    typedef struct packed {
        logic st4;
        logic st5;
        logic st6;
        logic st7;
    } hsl2rgb_adv_t;

endpackage

// ===== sv/hsl2rgb_ramp.sv =====
// ============================================================================
// hsl2rgb_ramp
// One color channel: piecewise-linear hue ramp between p and q, then scaling
// of the channel fraction to an 8-bit intensity. Covers stages 4 to 7.
// ============================================================================
module hsl2rgb_ramp #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  hsl2rgb_pkg::hsl2rgb_adv_t adv_i,
    input  logic [FRAC_BITS-1:0]      t_i,     // offset hue, stage 3
    input  logic [FRAC_BITS:0]        span_i,  // q - p, stage 4
    input  logic [FRAC_BITS:0]        p_i,     // stage 5
    input  logic [FRAC_BITS:0]        q_i,     // stage 5
    output logic [7:0]                chan_o   // stage 7
);
    import hsl2rgb_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int W1 = FB + 1;
    localparam int MW = W1 + FB;

    localparam logic [FB-1:0] SIXTH     = FB'((2 ** FRAC_BITS) / 6);
    localparam logic [FB-1:0] HALF      = FB'((2 ** FRAC_BITS) / 2);
    localparam logic [FB-1:0] TWOTHIRDS = FB'((2 * (2 ** FRAC_BITS)) / 3);

    typedef enum logic [1:0] {
        RGN_RISE,
        RGN_HIGH,
        RGN_FALL,
        RGN_LOW
    } rgn_t;

    rgn_t           rgn4_reg, rgn4_next, rgn5_reg;
    logic [FB-1:0]  dist4_reg, dist4_next;
    logic [MW-1:0]  mult5_reg;
    logic [MW+2:0]  mult6;
    logic [W1:0]    v_sum;
    logic [FB:0]    v6_reg, v6_next;
    logic [FB+8:0]  c_wide;
    logic [8:0]     c9;
    logic [7:0]     chan7_reg, chan7_next;

    // Stage 4: region of the hue ramp and distance along the slope
    always_comb begin
        if (t_i < SIXTH) begin
            rgn4_next = RGN_RISE;
        end else if (t_i < HALF) begin
            rgn4_next = RGN_HIGH;
        end else if (t_i < TWOTHIRDS) begin
            rgn4_next = RGN_FALL;
        end else begin
            rgn4_next = RGN_LOW;
        end
        dist4_next = (rgn4_next == RGN_FALL) ? TWOTHIRDS - t_i : t_i;
    end

    // Stage 6: 6*span*dist/ONE added to p, or a flat level
    always_comb begin
        mult6 = {1'b0, mult5_reg, 2'b00} + {2'b00, mult5_reg, 1'b0};
        v_sum = {1'b0, p_i} + {1'b0, mult6[FB +: W1]};
        unique case (rgn5_reg)
            RGN_RISE, RGN_FALL: v6_next = v_sum[FB:0];
            RGN_HIGH:           v6_next = q_i;
            RGN_LOW:            v6_next = p_i;
            default:            v6_next = p_i;
        endcase
    end

    // Stage 7: floor(255*v/ONE), clipped
    always_comb begin
        c_wide     = {v6_reg, 8'h00} - {8'h00, v6_reg};
        c9         = c_wide[FB+8:FB];
        chan7_next = c9[8] ? 8'hFF : c9[7:0];
    end

    always_ff @(posedge aclk) begin
        if (adv_i.st4) begin
            rgn4_reg  <= rgn4_next;
            dist4_reg <= dist4_next;
        end
        if (adv_i.st5) begin
            rgn5_reg  <= rgn4_reg;
            mult5_reg <= MW'(span_i) * MW'(dist4_reg);
        end
        if (adv_i.st6) begin
            v6_reg <= v6_next;
        end
        if (adv_i.st7) begin
            chan7_reg <= chan7_next;
        end
    end

    assign chan_o = chan7_reg;

endmodule

// ===== sv/hsl_to_rgb_converter.sv =====
// ============================================================================
// hsl_to_rgb_converter
// HSL (degrees, percent, percent) to 8-bit RGB, fully pipelined fixed point.
// ============================================================================
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------------
//   s_       | in        | s_valid / s_ready | hue_degrees, saturation_pct,
//            |           |                   | lightness_pct
//   m_       | out       | m_valid / m_ready | red, green, blue
//
// The path from request acceptance to m_valid runs through the seven
// register stages of the datapath (stage 1 loads at the accepting edge);
// one request per cycle is sustained while m_ready is high.
// Each stage has its own valid bit and a load enable that is high when the
// stage is empty or the stage after it loads, so bubbles are squeezed out
// and s_ready stays high while m_ready is low until all 7 stages are full.
// aresetn (synchronous, active low) clears only the valid bits.
//
// Stage plan:
//   1  hue wrap at 360, clamp to 100, split x*ONE/d into x*floor(ONE/d) and
//      the remainder product x*(ONE mod d)
//   2  remainder / d by reciprocal multiply, h, s, l fractions
//   3  l*s, red and blue hue offsets by one third with wrap
//   4  q and p; per channel ramp region (grey falls out: s = 0 gives p = q = l)
//   5  span * distance product
//   6  channel fraction
//   7  255*v/ONE, output register
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [8:0] s_hue_degrees,
    input  logic [6:0] s_saturation_pct,
    input  logic [6:0] s_lightness_pct,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue
);
    import hsl2rgb_pkg::*;

    localparam int FB = FRAC_BITS;
    localparam int W1 = FB + 1;

    // x*ONE/d == x*floor(ONE/d) + floor(x*(ONE mod d)/d)
    localparam int HUE_Q = (2 ** FRAC_BITS) / HUE_RANGE;
    localparam int HUE_R = (2 ** FRAC_BITS) % HUE_RANGE;
    localparam int PCT_Q = (2 ** FRAC_BITS) / PCT_MAX;
    localparam int PCT_R = (2 ** FRAC_BITS) % PCT_MAX;

    localparam logic [FB:0]   ONE       = W1'(2 ** FRAC_BITS);
    localparam logic [FB:0]   HALF      = W1'((2 ** FRAC_BITS) / 2);
    localparam logic [FB-1:0] THIRD     = FB'((2 ** FRAC_BITS) / 3);
    localparam logic [FB-1:0] ONE_THIRD_C = FB'((2 ** FRAC_BITS) - ((2 ** FRAC_BITS) / 3));

    // ---------------- valid chain and stage enables ----------------
    logic [PIPE_STAGES:1]   vld_reg;
    logic [PIPE_STAGES:1]   vld_in;
    logic [PIPE_STAGES+1:1] en;
    hsl2rgb_adv_t           adv;

    always_comb begin
        en[PIPE_STAGES+1] = m_ready;
        for (int k = PIPE_STAGES; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_in = {vld_reg[PIPE_STAGES-1:1], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 1; k <= PIPE_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    assign s_ready = en[1];
    assign m_valid = vld_reg[PIPE_STAGES];

    always_comb begin
        adv.st4 = en[4];
        adv.st5 = en[5];
        adv.st6 = en[6];
        adv.st7 = en[7];
    end

    // ---------------- stage 1: wrap, clamp, split products ----------------
    logic [8:0]    hue_w;
    logic [6:0]    sat_c, lit_c;
    logic [FB-1:0] hue_base_reg;
    logic [16:0]   hue_rem_reg;
    logic [FB:0]   sat_base_reg, lit_base_reg;
    logic [13:0]   sat_rem_reg, lit_rem_reg;

    always_comb begin
        hue_w = (s_hue_degrees >= HUE_RANGE) ? s_hue_degrees - HUE_RANGE : s_hue_degrees;
        sat_c = (s_saturation_pct > PCT_MAX) ? PCT_MAX : s_saturation_pct;
        lit_c = (s_lightness_pct > PCT_MAX) ? PCT_MAX : s_lightness_pct;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            hue_base_reg <= FB'(hue_w * HUE_Q);
            hue_rem_reg  <= 17'(hue_w * HUE_R);
            sat_base_reg <= W1'(sat_c * PCT_Q);
            sat_rem_reg  <= 14'(sat_c * PCT_R);
            lit_base_reg <= W1'(lit_c * PCT_Q);
            lit_rem_reg  <= 14'(lit_c * PCT_R);
        end
    end

    // ---------------- stage 2: remainder divides, h s l ----------------
    logic [34:0]   hue_prod;
    logic [27:0]   sat_prod, lit_prod;
    logic [FB-1:0] h2_reg;
    logic [FB:0]   s2_reg, l2_reg;

    always_comb begin
        hue_prod = 35'(hue_rem_reg) * 35'(HUE_RECIP);
        sat_prod = 28'(sat_rem_reg) * 28'(PCT_RECIP);
        lit_prod = 28'(lit_rem_reg) * 28'(PCT_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            h2_reg <= hue_base_reg + FB'(hue_prod[34:HUE_RECIP_SHIFT]);
            s2_reg <= sat_base_reg + W1'(sat_prod[27:PCT_RECIP_SHIFT]);
            l2_reg <= lit_base_reg + W1'(lit_prod[27:PCT_RECIP_SHIFT]);
        end
    end

    // ---------------- stage 3: l*s, hue offsets ----------------
    logic [2*W1-1:0] ls_prod;
    logic [FB:0]     tr_sum;
    logic [FB-1:0]   tr3_next, tb3_next;
    logic [FB-1:0]   tr3_reg, h3_reg, tb3_reg;
    logic [FB:0]     ls3_reg, s3_reg, l3_reg;

    always_comb begin
        ls_prod  = (2 * W1)'(l2_reg) * (2 * W1)'(s2_reg);
        tr_sum   = {1'b0, h2_reg} + {1'b0, THIRD};
        tr3_next = (tr_sum >= ONE) ? FB'(tr_sum - ONE) : tr_sum[FB-1:0];
        tb3_next = (h2_reg < THIRD) ? h2_reg + ONE_THIRD_C : h2_reg - THIRD;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            ls3_reg <= ls_prod[FB +: W1];
            s3_reg  <= s2_reg;
            l3_reg  <= l2_reg;
            tr3_reg <= tr3_next;
            h3_reg  <= h2_reg;
            tb3_reg <= tb3_next;
        end
    end

    // ---------------- stage 4: q, p, span ----------------
    logic [FB+1:0] q_sum, p_wide;
    logic [FB:0]   q4_next, p4_next;
    logic [FB:0]   q4_reg, p4_reg, span4_reg;
    logic [FB:0]   q5_reg, p5_reg;

    always_comb begin
        if (l3_reg < HALF) begin
            q_sum = {1'b0, l3_reg} + {1'b0, ls3_reg};
        end else begin
            q_sum = {1'b0, l3_reg} + {1'b0, s3_reg} - {1'b0, ls3_reg};
        end
        q4_next = q_sum[FB:0];
        p_wide  = {l3_reg, 1'b0} - {1'b0, q4_next};
        p4_next = p_wide[FB:0];
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            q4_reg    <= q4_next;
            p4_reg    <= p4_next;
            span4_reg <= q4_next - p4_next;
        end
        if (en[5]) begin
            q5_reg <= q4_reg;
            p5_reg <= p4_reg;
        end
    end

    // ---------------- stages 4..7: per-channel ramps ----------------
    hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
        .aclk   (aclk),
        .adv_i  (adv),
        .t_i    (tr3_reg),
        .span_i (span4_reg),
        .p_i    (p5_reg),
        .q_i    (q5_reg),
        .chan_o (m_red)
    );

    hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
        .aclk   (aclk),
        .adv_i  (adv),
        .t_i    (h3_reg),
        .span_i (span4_reg),
        .p_i    (p5_reg),
        .q_i    (q5_reg),
        .chan_o (m_green)
    );

    hsl2rgb_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
        .aclk   (aclk),
        .adv_i  (adv),
        .t_i    (tb3_reg),
        .span_i (span4_reg),
        .p_i    (p5_reg),
        .q_i    (q5_reg),
        .chan_o (m_blue)
    );

endmodule

// ===== sv/hsl2rgb_checker.sv =====
// ============================================================================
// hsl2rgb_checker
// Port-level checks on the converter: occupancy, free-flow and output hold.
// ============================================================================
module hsl2rgb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red,
    input logic [7:0] m_green,
    input logic [7:0] m_blue
);
    import hsl2rgb_pkg::*;

    localparam int CW = $clog2(PIPE_STAGES + 2);

    // requests accepted but not yet delivered
    logic [CW-1:0] flight_reg, flight_next;

    always_comb begin
        flight_next = flight_reg + CW'(s_valid && s_ready) - CW'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flight_reg <= '0;
        end else begin
            flight_reg <= flight_next;
        end
    end

    a_rst_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_empty_out_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while output stage empty");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        flight_reg <= CW'(PIPE_STAGES))
        else $error("more requests in flight than pipeline stages");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> flight_reg != '0)
        else $error("result shown with no request in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue))
        else $error("stalled result changed or dropped");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (.*);

// ===== sim/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for hsl_to_rgb_converter. A short directed table
// (grey, primaries, hue wrap, clamped fields) is followed by ~1400 random
// requests. Each accepted request's color, typed or from a fixed-point model
// of the HSL ramps, is queued. Every color the block returns is compared
// channel by channel with the oldest queued one. Both sides idle and stall at
// random, with one long output stall and input drains after the table, mid-run and at the end.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    // Fixed-point setup; the unit under test runs with its default width.
    localparam int          FRAC       = FRAC_BITS_DEF;
    localparam logic [63:0] ONE        = 64'd1 << FRAC;
    localparam int          N_RANDOM   = 1400;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          IDLE_PCT   = 12;
    // Requests in this window run with no idling on either side.
    localparam int          STEADY_LO  = 600;
    localparam int          STEADY_HI  = 800;
    // Output stall that fills the pipeline and backs up the input.
    localparam int          HOLD_AT    = 300;
    localparam int          HOLD_LEN   = 120;
    localparam int          DRAIN_AT   = 1000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // One directed request. When 'typed' is set the color is written in
    // directly; otherwise the model supplies it.
    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] lit;
        logic       typed;
        rgb_t       rgb;
    } stim_row_t;

    localparam int N_DIRECTED = 25;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        // grey cases read straight off lightness
        '{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{9'd0,   7'd0,   7'd50,  1'b1, '{8'd127, 8'd127, 8'd127}},
        // pure primaries
        '{9'd0,   7'd100, 7'd50,  1'b1, '{8'd255, 8'd0,   8'd0}},
        '{9'd120, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd255, 8'd0}},
        '{9'd240, 7'd100, 7'd50,  1'b1, '{8'd0,   8'd0,   8'd255}},
        // 360 wraps to red
        '{9'd360, 7'd100, 7'd50,  1'b1, '{8'd255, 8'd0,   8'd0}},
        // every field at all ones: hue wraps, sat/light clamp -> white
        '{9'd511, 7'd127, 7'd127, 1'b1, '{8'd255, 8'd255, 8'd255}},
        // clamped saturation at zero lightness -> black
        '{9'd0,   7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        // secondaries, ramp boundaries, wrap above 360, odd clamps
        '{9'd60,  7'd100, 7'd50,  1'b0, '0},
        '{9'd180, 7'd100, 7'd50,  1'b0, '0},
        '{9'd300, 7'd100, 7'd50,  1'b0, '0},
        '{9'd359, 7'd100, 7'd50,  1'b0, '0},
        '{9'd361, 7'd100, 7'd50,  1'b0, '0},
        '{9'd480, 7'd60,  7'd30,  1'b0, '0},
        '{9'd1,   7'd1,   7'd1,   1'b0, '0},
        '{9'd30,  7'd50,  7'd25,  1'b0, '0},
        '{9'd210, 7'd75,  7'd75,  1'b0, '0},
        '{9'd59,  7'd100, 7'd40,  1'b0, '0},
        '{9'd61,  7'd100, 7'd60,  1'b0, '0},
        '{9'd179, 7'd100, 7'd50,  1'b0, '0},
        '{9'd239, 7'd33,  7'd67,  1'b0, '0},
        '{9'd0,   7'd101, 7'd50,  1'b0, '0},
        '{9'd45,  7'd50,  7'd101, 1'b0, '0},
        '{9'd256, 7'd64,  7'd64,  1'b0, '0}
    };

    localparam logic [8:0] HUE_EDGES [8] = '{9'd0, 9'd60, 9'd120, 9'd180,
                                            9'd240, 9'd300, 9'd359, 9'd360};
    localparam logic [6:0] PCT_EDGES [8] = '{7'd0, 7'd1, 7'd49, 7'd50,
                                            7'd51, 7'd99, 7'd100, 7'd127};

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [8:0] s_hue_degrees;
    logic [6:0] s_saturation_pct;
    logic [6:0] s_lightness_pct;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_red;
    logic [7:0] m_green;
    logic [7:0] m_blue;

    rgb_t pending_rgb[$];   // colors owed by the block, oldest first
    int   n_accepted;       // requests taken by the block so far
    bit   steady;           // no idling on either side while set
    int   n_errors;
    int   cycles;

    hsl_to_rgb_converter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_hue_degrees    (s_hue_degrees),
        .s_saturation_pct (s_saturation_pct),
        .s_lightness_pct  (s_lightness_pct),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red            (m_red),
        .m_green          (m_green),
        .m_blue           (m_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Color model
    // ------------------------------------------------------------------------

    // Piecewise-linear channel ramp over the (offset) hue fraction t.
    function automatic logic [63:0] hue_ramp(logic [63:0] p, logic [63:0] q,
                                             logic [63:0] t);
        logic [63:0] sixth, half, two_thirds, span;
        sixth      = ONE / 6;
        half       = ONE / 2;
        two_thirds = (2 * ONE) / 3;
        span       = q - p;
        if (t < sixth)
            return p + ((span * 6 * t) >> FRAC);
        if (t < half)
            return q;
        if (t < two_thirds)
            return p + ((span * (two_thirds - t) * 6) >> FRAC);
        return p;
    endfunction

    // Fraction to 8-bit level, truncated and saturated.
    function automatic logic [7:0] to_level(logic [63:0] v);
        logic [63:0] c;
        c = (64'd255 * v) >> FRAC;
        return (c > 64'd255) ? 8'd255 : c[7:0];
    endfunction

    function automatic rgb_t model_color(logic [8:0] hue_in, logic [6:0] sat_in,
                                         logic [6:0] lit_in);
        logic [63:0] hue, sat, lit, h, s, l, ls, q, p, third, t_red, t_blue;
        rgb_t        c;
        hue = 64'(hue_in);
        sat = 64'(sat_in);
        lit = 64'(lit_in);
        if (hue >= 64'(HUE_RANGE))
            hue = hue - 64'(HUE_RANGE);
        if (sat > 64'(PCT_MAX))
            sat = 64'(PCT_MAX);
        if (lit > 64'(PCT_MAX))
            lit = 64'(PCT_MAX);
        h = (hue * ONE) / 64'(HUE_RANGE);
        s = (sat * ONE) / 64'(PCT_MAX);
        l = (lit * ONE) / 64'(PCT_MAX);
        if (sat == 0) begin
            c.red   = to_level(l);
            c.green = to_level(l);
            c.blue  = to_level(l);
        end else begin
            ls    = (l * s) >> FRAC;
            third = ONE / 3;
            q     = (l < ONE / 2) ? l + ls : l + s - ls;
            p     = 2 * l - q;
            // red leads by a third, blue lags by a third, both wrap into [0,1)
            t_red = h + third;
            if (t_red >= ONE)
                t_red = t_red - ONE;
            t_blue = (h < third) ? h + ONE - third : h - third;
            c.red   = to_level(hue_ramp(p, q, t_red));
            c.green = to_level(hue_ramp(p, q, h));
            c.blue  = to_level(hue_ramp(p, q, t_blue));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer a request and wait until it is taken. Entered right after aclk
    // rises; leaves s_valid high so a back-to-back request keeps it up.
    task automatic offer(logic [8:0] hue, logic [6:0] sat, logic [6:0] lit,
                         logic typed, rgb_t typed_rgb);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 30);
        end
        s_valid          <= 1'b1;
        s_hue_degrees    <= hue;
        s_saturation_pct <= sat;
        s_lightness_pct  <= lit;
        do @(posedge aclk); while (!s_ready);
        pending_rgb.push_back(typed ? typed_rgb : model_color(hue, sat, lit));
        n_accepted++;
    endtask

    // Drop valid and wait until every owed color has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [8:0] hue;
        logic [6:0] sat, lit;
        int         mode;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_hue_degrees    = '0;
        s_saturation_pct = '0;
        s_lightness_pct  = '0;
        n_accepted       = 0;
        steady           = 1'b0;
        n_errors         = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].lit,
                  DIRECTED[i].typed, DIRECTED[i].rgb);
        drain();

        // Random part: mostly legal colors, some raw bit patterns, some edges
        for (int i = 0; i < N_RANDOM; i++) begin
            steady = (i >= STEADY_LO && i < STEADY_HI);
            if (i == DRAIN_AT)
                drain();
            mode = $urandom_range(99);
            if (mode < 75) begin
                hue = 9'($urandom_range(359));
                sat = ($urandom_range(19) == 0) ? 7'd0 : 7'($urandom_range(100));
                lit = 7'($urandom_range(100));
            end else if (mode < 88) begin
                hue = 9'($urandom_range(511));
                sat = 7'($urandom_range(127));
                lit = 7'($urandom_range(127));
            end else begin
                hue = HUE_EDGES[$urandom_range(7)];
                sat = PCT_EDGES[$urandom_range(7)];
                lit = PCT_EDGES[$urandom_range(7)];
            end
            offer(hue, sat, lit, 1'b0, '0);
        end
        steady = 1'b0;
        drain();

        // Catch anything extra the pipeline might still push out.
        repeat (3 * PIPE_STAGES) @(posedge aclk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Random backpressure, plus one long hold-off once enough requests have
    // gone in, so the pipeline fills and s_ready drops.
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && n_accepted >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each returned color with the oldest owed one.
    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $error("unexpected color r=%0d g=%0d b=%0d", m_red, m_green, m_blue);
                n_errors++;
            end else begin
                want = pending_rgb.pop_front();
                if (m_red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, m_red);
                    n_errors++;
                end
                if (m_green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, m_green);
                    n_errors++;
                end
                if (m_blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, m_blue);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
